// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the thrust gain estimator.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop on every rising clock edge outside reset
`define TGRLS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check that cond never holds outside reset
`define TGRLS_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/tgrls_pkg.sv =====
// ---------------------------------------------------------------------------
// Thrust gain estimator package
// Types, codes and fixed-point constants shared across the estimator.
// ---------------------------------------------------------------------------
package tgrls_pkg;

  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_MEAS = 2'd1,
    KIND_RST  = 2'd2
  } kind_e;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORGET    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_MIN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_MAX   = 2'd3;

  localparam logic [31:0] INIT_GAIN_RST = 32'd1284506;
  localparam logic [16:0] FORGET_RST    = 17'd65405;
  localparam logic [19:0] WIN_MIN_RST   = 20'd35000;
  localparam logic [19:0] WIN_MAX_RST   = 20'd45000;

  localparam int HISTORY_CAP = 100;
  localparam logic signed [31:0] HALF_G_Q16 = 32'sd321127;
  localparam logic [15:0] THR_MIN = 16'd3277;
  localparam logic [15:0] THR_MAX = 16'hFFFF;
  localparam logic [47:0] P_INIT  = 48'd16777216000000;
  localparam logic [47:0] P_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [30:0] K_MAX   = 31'h4000_0000;

  localparam int DEN_W  = 49;
  localparam int LOW_W  = 48;
  localparam int QUO_W  = 48;
  localparam int STEP_W = 6;

  localparam logic [STEP_W-1:0] STEPS_CMD = 6'd16;
  localparam logic [STEP_W-1:0] STEPS_K   = 6'd31;
  localparam logic [STEP_W-1:0] STEPS_P   = 6'd48;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        time_us;
    logic signed [31:0] accel_z;
  } item_t;

  typedef struct packed {
    logic [31:0] init_gain;
    logic [16:0] forget;
    logic [19:0] win_min;
    logic [19:0] win_max;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DEN_W-1:0]  rem;
    logic [LOW_W-1:0]  low;
    logic [DEN_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

// ===== hw/rtl/tgrls_intf.sv =====
// ---------------------------------------------------------------------------
// Estimator channel interfaces
// Item, result and register write channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface tgrls_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [31:0]        time_us;
  logic signed [31:0] accel_z;
  modport source (output valid, kind, time_us, accel_z, input ready);
  modport sink (input valid, kind, time_us, accel_z, output ready);
endinterface

interface tgrls_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] throttle;
  logic        model_updated;
  logic [31:0] thrust_gain;
  modport source (output valid, throttle, model_updated, thrust_gain, input ready);
  modport sink (input valid, throttle, model_updated, thrust_gain, output ready);
endinterface

interface tgrls_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/tgrls_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module tgrls_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tgrls_div.sv =====
// ---------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle from a preloaded remainder and numerator tail.
// ---------------------------------------------------------------------------
module tgrls_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tgrls_pkg::div_req_t               req_i,
  output logic                              done_o,
  output logic [tgrls_pkg::QUO_W-1:0]       quo_o
);

  logic [tgrls_pkg::DEN_W-1:0]  rem_q, rem_d;
  logic [tgrls_pkg::LOW_W-1:0]  low_q, low_d;
  logic [tgrls_pkg::DEN_W-1:0]  den_q, den_d;
  logic [tgrls_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic [tgrls_pkg::QUO_W-1:0]  quo_q, quo_d;
  logic                         run_q, run_d;
  logic                         done_q, done_d;
  logic [tgrls_pkg::DEN_W:0]    trial;
  logic                         fits;

  assign trial = {rem_q, low_q[tgrls_pkg::LOW_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = req_i.rem;
      low_d = req_i.low;
      den_d = req_i.den;
      cnt_d = req_i.steps;
      quo_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = fits ? tgrls_pkg::DEN_W'(trial - {1'b0, den_q})
                   : tgrls_pkg::DEN_W'(trial);
      low_d = {low_q[tgrls_pkg::LOW_W-2:0], 1'b0};
      quo_d = {quo_q[tgrls_pkg::QUO_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == tgrls_pkg::STEP_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== hw/rtl/tgrls_front.sv =====
// ---------------------------------------------------------------------------
// Estimator front end
// Accept item beats and hold them in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tgrls_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  tgrls_item_if.sink        item_i,
  output logic              item_valid_o,
  output tgrls_pkg::item_t  item_o,
  input  logic              item_take_i
);

  tgrls_pkg::item_t buf_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             push;
  logic             pop;

  assign item_i.ready = cnt_q != 2'd2;
  assign push         = item_i.valid && item_i.ready;
  assign pop          = item_take_i && (cnt_q != 2'd0);
  assign item_valid_o = cnt_q != 2'd0;
  assign item_o       = buf_q[rd_q];

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = pop ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= '{kind: item_i.kind, time_us: item_i.time_us, accel_z: item_i.accel_z};
    end
  end

  `TGRLS_NEVER(a_queue_overflow, clk_i, rst_ni, cnt_q == 2'd3, "item queue over depth")

endmodule

// ===== hw/rtl/tgrls_back.sv =====
// ---------------------------------------------------------------------------
// Estimator back end
// Throttle mapping, history queue walk and RLS gain/covariance update.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tgrls_back #(
  parameter int DEPTH = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tgrls_pkg::cfg_t   cfg_i,
  input  logic              item_valid_i,
  input  tgrls_pkg::item_t  item_i,
  output logic              item_take_o,
  tgrls_result_if.source    result_o
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int CAP = (tgrls_pkg::HISTORY_CAP < DEPTH) ? tgrls_pkg::HISTORY_CAP : DEPTH;
  localparam logic [CW-1:0] CAP_C   = CW'(CAP);
  localparam logic [AW:0]   DEPTH_C = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CDIV, S_CWR, S_MRD, S_MCHK, S_R1, S_R2, S_R3,
    S_KDIV, S_R4, S_R5, S_PDIV
  } state_e;

  state_e             st_q, st_d;
  logic [AW-1:0]      head_q, head_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [31:0]        gain_q, gain_d;
  logic [47:0]        cov_q, cov_d;
  logic [31:0]        time_q, time_d;
  logic signed [31:0] acc_q, acc_d;
  logic [15:0]        thr_q, thr_d;
  logic [47:0]        pt_q, pt_d;
  logic [48:0]        d_q, d_d;
  logic signed [33:0] err_q, err_d;
  logic               ksat_q, ksat_d;
  logic               psat_q, psat_d;
  logic [30:0]        k_q, k_d;
  logic [40:0]        delta_q, delta_d;
  logic               neg_q, neg_d;
  logic               ov_q, ov_d;
  logic [15:0]        othr_q, othr_d;
  logic               oupd_q, oupd_d;
  logic [31:0]        ogain_q, ogain_d;

  tgrls_pkg::div_req_t            div_req;
  logic                           div_done;
  logic [tgrls_pkg::QUO_W-1:0]    div_quo;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [47:0]                    ram_rdata;

  logic                           out_free;
  logic                           half_g;
  logic [32:0]                    den_cmd;
  logic                           z_ge_den;
  logic [15:0]                    thr_div;
  logic [63:0]                    mul_pt;
  logic [63:0]                    mul_pp;
  logic [47:0]                    mul_pred;
  logic [64:0]                    mul_dk;
  logic [16:0]                    rho;
  logic [33:0]                    mag;
  logic signed [42:0]             g_sum;
  logic [31:0]                    gain_sat;
  logic [31:0]                    age;
  logic                           full;
  logic [AW-1:0]                  head_inc;
  logic [AW-1:0]                  wr_head;
  logic [CW-1:0]                  wr_cnt;
  logic [AW:0]                    slot_sum;

  assign out_free = !ov_q || result_o.ready;
  assign half_g   = item_i.accel_z < tgrls_pkg::HALF_G_Q16;
  assign den_cmd  = half_g ? {gain_q, 1'b0} : {1'b0, gain_q};
  assign z_ge_den = {1'b0, item_i.accel_z} >= den_cmd;
  assign thr_div  = (div_quo[15:0] < tgrls_pkg::THR_MIN) ? tgrls_pkg::THR_MIN : div_quo[15:0];
  assign mul_pt   = cov_q * thr_q;
  assign mul_pp   = pt_q * thr_q;
  assign mul_pred = gain_q * thr_q;
  assign rho      = (cfg_i.forget == '0) ? 17'd1 : cfg_i.forget;
  assign mag      = err_q[33] ? 34'(-err_q) : 34'(err_q);
  assign mul_dk   = mag * k_q;
  assign g_sum    = neg_q ? $signed({11'b0, gain_q}) - $signed({2'b0, delta_q})
                          : $signed({11'b0, gain_q}) + $signed({2'b0, delta_q});
  assign gain_sat = g_sum[42] ? 32'd0 : ((|g_sum[41:32]) ? 32'hFFFF_FFFF : g_sum[31:0]);
  assign age      = time_q - ram_rdata[47:16];
  assign full     = cnt_q >= CAP_C;
  assign head_inc = (head_q == LAST_C) ? '0 : head_q + 1'b1;
  assign wr_head  = full ? head_inc : head_q;
  assign wr_cnt   = full ? cnt_q - 1'b1 : cnt_q;
  assign slot_sum = {1'b0, wr_head} + (AW + 1)'(wr_cnt);
  assign ram_waddr = (slot_sum >= DEPTH_C) ? AW'(slot_sum - DEPTH_C) : AW'(slot_sum);

  always_comb begin
    st_d    = st_q;
    head_d  = head_q;
    cnt_d   = cnt_q;
    gain_d  = gain_q;
    cov_d   = cov_q;
    time_d  = time_q;
    acc_d   = acc_q;
    thr_d   = thr_q;
    pt_d    = pt_q;
    d_d     = d_q;
    err_d   = err_q;
    ksat_d  = ksat_q;
    psat_d  = psat_q;
    k_d     = k_q;
    delta_d = delta_q;
    neg_d   = neg_q;
    ov_d    = ov_q && !result_o.ready;
    othr_d  = othr_q;
    oupd_d  = oupd_q;
    ogain_d = ogain_q;
    div_req = '0;
    ram_we  = 1'b0;
    item_take_o = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (item_valid_i && out_free) begin
          item_take_o = 1'b1;
          time_d = item_i.time_us;
          acc_d  = item_i.accel_z;
          case (tgrls_pkg::kind_e'(item_i.kind))
            tgrls_pkg::KIND_CMD: begin
              st_d = S_CWR;
              if (item_i.accel_z <= 32'sd0) begin
                thr_d = tgrls_pkg::THR_MIN;
              end else if (gain_q == '0 || z_ge_den) begin
                thr_d = tgrls_pkg::THR_MAX;
              end else begin
                div_req.start = 1'b1;
                div_req.rem   = tgrls_pkg::DEN_W'(item_i.accel_z);
                div_req.low   = '0;
                div_req.den   = tgrls_pkg::DEN_W'(den_cmd);
                div_req.steps = tgrls_pkg::STEPS_CMD;
                st_d = S_CDIV;
              end
            end
            tgrls_pkg::KIND_MEAS: begin
              st_d = S_MRD;
            end
            tgrls_pkg::KIND_RST: begin
              gain_d  = cfg_i.init_gain;
              cov_d   = tgrls_pkg::P_INIT;
              ov_d    = 1'b1;
              othr_d  = '0;
              oupd_d  = 1'b0;
              ogain_d = cfg_i.init_gain;
            end
            default: begin
              ov_d    = 1'b1;
              othr_d  = '0;
              oupd_d  = 1'b0;
              ogain_d = gain_q;
            end
          endcase
        end
      end
      S_CDIV: begin
        if (div_done) begin
          thr_d = thr_div;
          st_d  = S_CWR;
        end
      end
      S_CWR: begin
        ram_we  = 1'b1;
        head_d  = wr_head;
        cnt_d   = wr_cnt + 1'b1;
        ov_d    = 1'b1;
        othr_d  = thr_q;
        oupd_d  = 1'b0;
        ogain_d = gain_q;
        st_d    = S_IDLE;
      end
      S_MRD: begin
        if (cnt_q == '0) begin
          ov_d    = 1'b1;
          othr_d  = '0;
          oupd_d  = 1'b0;
          ogain_d = gain_q;
          st_d    = S_IDLE;
        end else begin
          st_d = S_MCHK;
        end
      end
      S_MCHK: begin
        if (age > {12'b0, cfg_i.win_max}) begin
          head_d = head_inc;
          cnt_d  = cnt_q - 1'b1;
          st_d   = S_MRD;
        end else if (age < {12'b0, cfg_i.win_min}) begin
          ov_d    = 1'b1;
          othr_d  = '0;
          oupd_d  = 1'b0;
          ogain_d = gain_q;
          st_d    = S_IDLE;
        end else begin
          head_d = head_inc;
          cnt_d  = cnt_q - 1'b1;
          thr_d  = ram_rdata[15:0];
          st_d   = S_R1;
        end
      end
      S_R1: begin
        pt_d = mul_pt[63:16];
        st_d = S_R2;
      end
      S_R2: begin
        d_d  = 49'({rho, 8'b0}) + 49'(mul_pp[63:16]);
        st_d = S_R3;
      end
      S_R3: begin
        err_d  = $signed({{2{acc_q[31]}}, acc_q}) - $signed({2'b0, mul_pred[47:16]});
        ksat_d = {8'b0, pt_q} >= {d_q, 7'b0};
        div_req.start = 1'b1;
        div_req.rem   = tgrls_pkg::DEN_W'(pt_q[47:7]);
        div_req.low   = {pt_q[6:0], 41'b0};
        div_req.den   = d_q;
        div_req.steps = tgrls_pkg::STEPS_K;
        st_d = S_KDIV;
      end
      S_KDIV: begin
        if (div_done) begin
          k_d  = (ksat_q || div_quo[30:0] > tgrls_pkg::K_MAX) ? tgrls_pkg::K_MAX
                                                              : div_quo[30:0];
          st_d = S_R4;
        end
      end
      S_R4: begin
        delta_d = mul_dk[64:24];
        neg_d   = err_q[33];
        st_d    = S_R5;
      end
      S_R5: begin
        gain_d = gain_sat;
        psat_d = {25'b0, cov_q} >= {d_q, 24'b0};
        div_req.start = 1'b1;
        div_req.rem   = tgrls_pkg::DEN_W'(cov_q[47:24]);
        div_req.low   = {cov_q[23:0], 24'b0};
        div_req.den   = d_q;
        div_req.steps = tgrls_pkg::STEPS_P;
        st_d = S_PDIV;
      end
      S_PDIV: begin
        if (div_done) begin
          cov_d   = psat_q ? tgrls_pkg::P_MAX : div_quo;
          ov_d    = 1'b1;
          othr_d  = '0;
          oupd_d  = 1'b1;
          ogain_d = gain_q;
          st_d    = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      head_q <= '0;
      cnt_q  <= '0;
      gain_q <= tgrls_pkg::INIT_GAIN_RST;
      cov_q  <= tgrls_pkg::P_INIT;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      head_q <= head_d;
      cnt_q  <= cnt_d;
      gain_q <= gain_d;
      cov_q  <= cov_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q  <= time_d;
    acc_q   <= acc_d;
    thr_q   <= thr_d;
    pt_q    <= pt_d;
    d_q     <= d_d;
    err_q   <= err_d;
    ksat_q  <= ksat_d;
    psat_q  <= psat_d;
    k_q     <= k_d;
    delta_q <= delta_d;
    neg_q   <= neg_d;
    othr_q  <= othr_d;
    oupd_q  <= oupd_d;
    ogain_q <= ogain_d;
  end

  tgrls_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  tgrls_ram #(
    .WIDTH (48),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({time_q, thr_q}),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign result_o.valid         = ov_q;
  assign result_o.throttle      = othr_q;
  assign result_o.model_updated = oupd_q;
  assign result_o.thrust_gain   = ogain_q;

  `TGRLS_ASSERT(a_cnt_cap, clk_i, rst_ni, cnt_q <= CAP_C, "history count above cap")
  `TGRLS_ASSERT(a_head_range, clk_i, rst_ni, {1'b0, head_q} < DEPTH_C, "history head out of range")
  `TGRLS_ASSERT(a_upd_thr, clk_i, rst_ni, (ov_q && oupd_q) |-> (othr_q == '0), "update with throttle")
  `TGRLS_ASSERT(a_take_idle, clk_i, rst_ni, item_take_o |-> (st_q == S_IDLE), "item taken while busy")

endmodule

// ===== hw/rtl/thrust_gain_rls_estimator_top.sv =====
// ---------------------------------------------------------------------------
// Thrust gain RLS estimator
// Throttle mapping with online acceleration-per-throttle gain learning.
// ---------------------------------------------------------------------------
// Command: mapped directly, or through the 16-step quotient in the divider.
// Measurement: each stale history entry is dropped in turn through the
// registered-read history RAM; an update adds 31-step and 48-step
// divides on the shared divider. Reset and unknown items answer from idle.
// One item in the back end at a time; two more items queue at the input.
// Reset: asynchronous, active low; control and config registers return to their defaults.
module thrust_gain_rls_estimator_top #(
  parameter int HISTORY_DEPTH = 128
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  tgrls_item_if.sink     item_i,
  tgrls_result_if.source result_o,
  tgrls_cfg_if.sink      cfg_i
);

  tgrls_pkg::cfg_t  cfg_q, cfg_d;
  logic             item_valid;
  tgrls_pkg::item_t item;
  logic             item_take;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        tgrls_pkg::REG_INIT_GAIN: cfg_d.init_gain = cfg_i.data;
        tgrls_pkg::REG_FORGET:    cfg_d.forget    = cfg_i.data[16:0];
        tgrls_pkg::REG_WIN_MIN:   cfg_d.win_min   = cfg_i.data[19:0];
        tgrls_pkg::REG_WIN_MAX:   cfg_d.win_max   = cfg_i.data[19:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_gain <= tgrls_pkg::INIT_GAIN_RST;
      cfg_q.forget    <= tgrls_pkg::FORGET_RST;
      cfg_q.win_min   <= tgrls_pkg::WIN_MIN_RST;
      cfg_q.win_max   <= tgrls_pkg::WIN_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tgrls_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  tgrls_back #(
    .DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .result_o     (result_o)
  );

endmodule

// ===== tb/thrust_gain_rls_estimator_top_tb.sv =====
// ---------------------------------------------------------------------------
// Thrust gain estimator testbench
// Drives command, measurement and reset beats through the item channel and
// checks every result against a cycle-free model of the throttle mapping and
// the scalar RLS gain update, across several register settings and idling
// phases.
// ---------------------------------------------------------------------------
module thrust_gain_rls_estimator_top_tb;

  typedef struct packed {
    logic [15:0] throttle;
    logic        model_updated;
    logic [31:0] thrust_gain;
  } result_t;

  localparam logic [1:0] KIND_BAD = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tgrls_item_if   item_if ();
  tgrls_result_if result_if ();
  tgrls_cfg_if    cfg_if ();

  thrust_gain_rls_estimator_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if.sink),
    .result_o (result_if.source),
    .cfg_i    (cfg_if.sink)
  );

  // predictor state
  logic [31:0] cfg_init_gain;
  logic [16:0] cfg_forget;
  logic [19:0] cfg_win_min;
  logic [19:0] cfg_win_max;
  logic [31:0] hist_time [128];
  logic [15:0] hist_thr [128];
  int unsigned hist_head;
  int unsigned hist_count;
  logic [31:0] gain_q;
  logic [63:0] cov_q;

  result_t expected_results[$];
  int      mismatch_count;
  int      send_idle_pct;
  int      stall_pct;
  int      hold_off_cycles;
  logic [31:0] now_us;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("thrust_gain_rls_estimator_top_tb: FAIL");
    $finish;
  end

  function automatic logic [63:0] div_shift(logic [63:0] num, int sh, logic [63:0] den);
    logic [127:0] wide;
    logic [127:0] q;
    wide = {64'd0, num} << sh;
    q = wide / {64'd0, den};
    return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
  endfunction

  function automatic logic [15:0] map_throttle(logic [31:0] t, logic signed [31:0] z);
    logic [15:0] thr;
    logic [63:0] den;
    logic [63:0] q;
    if (z <= 0) thr = tgrls_pkg::THR_MIN;
    else if (gain_q == 0) thr = tgrls_pkg::THR_MAX;
    else begin
      den = {32'd0, gain_q} << ((z < tgrls_pkg::HALF_G_Q16) ? 1 : 0);
      q = ({32'd0, z} << 16) / den;
      thr = (q < tgrls_pkg::THR_MIN) ? tgrls_pkg::THR_MIN
          : ((q > tgrls_pkg::THR_MAX) ? tgrls_pkg::THR_MAX : q[15:0]);
    end
    if (hist_count >= tgrls_pkg::HISTORY_CAP) begin
      hist_head = (hist_head + 1) % 128;
      hist_count--;
    end
    hist_time[(hist_head + hist_count) % 128] = t;
    hist_thr[(hist_head + hist_count) % 128] = thr;
    hist_count++;
    return thr;
  endfunction

  function automatic void update_gain(logic [63:0] thr, logic signed [31:0] a);
    logic [63:0] rho, pt, d, k, mag, p;
    logic signed [63:0] pred, err, delta, g;
    rho = (cfg_forget != 0) ? {47'd0, cfg_forget} : 64'd1;
    pt = (cov_q * thr) >> 16;
    d = (rho << 8) + ((pt * thr) >> 16);
    k = div_shift(pt, 24, d);
    if (k > tgrls_pkg::K_MAX) k = tgrls_pkg::K_MAX;
    pred = (({32'd0, gain_q} * thr) >> 16);
    err = 64'(a) - pred;
    mag = (err < 0) ? -err : err;
    delta = (mag * k) >> 24;
    if (err < 0) delta = -delta;
    g = $signed({32'd0, gain_q}) + delta;
    if (g < 0) g = 0;
    if (g > 64'sh0_FFFF_FFFF) g = 64'sh0_FFFF_FFFF;
    gain_q = g[31:0];
    p = div_shift(cov_q, 24, d);
    cov_q = (p > tgrls_pkg::P_MAX) ? tgrls_pkg::P_MAX : p;
  endfunction

  function automatic logic pair_measurement(logic [31:0] t, logic signed [31:0] a);
    logic [31:0] age;
    while (hist_count > 0) begin
      age = t - hist_time[hist_head];
      if (age > cfg_win_max) begin
        hist_head = (hist_head + 1) % 128;
        hist_count--;
        continue;
      end
      if (age < cfg_win_min) return 1'b0;
      update_gain({48'd0, hist_thr[hist_head]}, a);
      hist_head = (hist_head + 1) % 128;
      hist_count--;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t predict_result(logic [1:0] kind, logic [31:0] t,
                                             logic signed [31:0] a);
    result_t r;
    r = '0;
    if (kind == tgrls_pkg::KIND_CMD) r.throttle = map_throttle(t, a);
    else if (kind == tgrls_pkg::KIND_MEAS) r.model_updated = pair_measurement(t, a);
    else if (kind == tgrls_pkg::KIND_RST) begin
      gain_q = cfg_init_gain;
      cov_q = {16'd0, tgrls_pkg::P_INIT};
    end
    r.thrust_gain = gain_q;
    return r;
  endfunction

  task automatic send_beat(logic [1:0] kind, logic [31:0] t, logic signed [31:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.kind <= kind;
    item_if.time_us <= t;
    item_if.accel_z <= a;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    expected_results.push_back(predict_result(kind, t, a));
  endtask

  task automatic drain();
    item_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    case (idx)
      tgrls_pkg::REG_INIT_GAIN: cfg_init_gain = value;
      tgrls_pkg::REG_FORGET:    cfg_forget = value[16:0];
      tgrls_pkg::REG_WIN_MIN:   cfg_win_min = value[19:0];
      default:                  cfg_win_max = value[19:0];
    endcase
    @(posedge clk_i);
  endtask

  // result checker and receiver stall
  always @(posedge clk_i) begin
    result_t got, exp_r;
    if (result_if.valid && result_if.ready) begin
      got = {result_if.throttle, result_if.model_updated, result_if.thrust_gain};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat %h", got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp thr %0d upd %0d gain %h, got thr %0d upd %0d gain %h",
                     exp_r.throttle, exp_r.model_updated, exp_r.thrust_gain,
                     got.throttle, got.model_updated, got.thrust_gain);
        end
      end
    end
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic test_directed();
    send_beat(tgrls_pkg::KIND_CMD, now_us, 32'sd642254);
    send_beat(tgrls_pkg::KIND_CMD, now_us + 1000, 32'sd300000);
    send_beat(tgrls_pkg::KIND_CMD, now_us + 2000, 32'sh7FFF_FFFF);
    send_beat(tgrls_pkg::KIND_CMD, now_us + 3000, 32'sh8000_0000);
    send_beat(tgrls_pkg::KIND_CMD, now_us + 4000, 32'sd0);
    send_beat(tgrls_pkg::KIND_CMD, now_us + 5000, tgrls_pkg::HALF_G_Q16);
    send_beat(tgrls_pkg::KIND_MEAS, now_us + 10000, 32'sd642254);
    send_beat(tgrls_pkg::KIND_MEAS, now_us + 38000, 32'sd642254);
    send_beat(tgrls_pkg::KIND_MEAS, now_us + 39000, 32'sh7FFF_FFFF);
    send_beat(tgrls_pkg::KIND_MEAS, now_us + 40000, 32'sh8000_0000);
    send_beat(tgrls_pkg::KIND_MEAS, now_us + 200000, 32'sd1);
    send_beat(tgrls_pkg::KIND_MEAS, now_us + 200000, 32'sd1);
    send_beat(tgrls_pkg::KIND_RST, now_us, 32'sd5);
    send_beat(KIND_BAD, 32'hFFFF_FFFF, 32'sh5555_AAAA);
    for (int i = 0; i < 105; i++)
      send_beat(tgrls_pkg::KIND_CMD, now_us + 300000 + i, 32'sd700000);
    send_beat(tgrls_pkg::KIND_MEAS, now_us + 300200, 32'sd1);
    now_us += 400000;
    drain();
  endtask

  // random command and measurement beats with occasional reset and bad-kind noise
  task automatic test_random(int n);
    logic [1:0] kind;
    logic signed [31:0] a;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      now_us += $urandom_range(12000);
      if (r < 5) now_us = $urandom;
      a = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1500000) - 100000;
      if (r < 50) kind = tgrls_pkg::KIND_CMD;
      else if (r < 95) kind = tgrls_pkg::KIND_MEAS;
      else if (r < 98) kind = tgrls_pkg::KIND_RST;
      else kind = KIND_BAD;
      send_beat(kind, now_us, a);
    end
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 2000;
    for (int i = 0; i < 20; i++) send_beat(tgrls_pkg::KIND_CMD, now_us + i, $urandom);
    drain();
    send_beat(tgrls_pkg::KIND_MEAS, now_us + 40000, 32'sd642254);
    drain();
  endtask

  task automatic test_config(logic [31:0] g, logic [31:0] f, logic [31:0] mn,
                             logic [31:0] mx, int n);
    write_reg(tgrls_pkg::REG_INIT_GAIN, g);
    write_reg(tgrls_pkg::REG_FORGET, f);
    write_reg(tgrls_pkg::REG_WIN_MIN, mn);
    write_reg(tgrls_pkg::REG_WIN_MAX, mx);
    send_beat(tgrls_pkg::KIND_RST, now_us, 0);
    test_random(n);
    drain();
  endtask

  initial begin
    item_if.valid = 1'b0;
    item_if.kind = '0;
    item_if.time_us = '0;
    item_if.accel_z = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    result_if.ready = 1'b0;
    cfg_init_gain = tgrls_pkg::INIT_GAIN_RST;
    cfg_forget = tgrls_pkg::FORGET_RST;
    cfg_win_min = tgrls_pkg::WIN_MIN_RST;
    cfg_win_max = tgrls_pkg::WIN_MAX_RST;
    hist_head = 0;
    hist_count = 0;
    gain_q = tgrls_pkg::INIT_GAIN_RST;
    cov_q = {16'd0, tgrls_pkg::P_INIT};
    mismatch_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off_cycles = 0;
    now_us = 32'hFFFF_0000;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(300);
    send_idle_pct = 69;
    test_random(300);
    send_idle_pct = 0;
    stall_pct = 69;
    test_random(300);
    send_idle_pct = 30;
    stall_pct = 30;
    test_random(200);
    drain();
    test_backpressure();
    test_config(32'hFFFF_FFFF, 32'd65536, 32'd0, 32'd1000000, 150);
    test_config(32'd0, 32'd1, 32'd1000000, 32'd0, 100);
    test_config(32'd20000, 32'd0, 32'd2000, 32'd9000, 150);
    test_config(tgrls_pkg::INIT_GAIN_RST, 32'(tgrls_pkg::FORGET_RST),
                32'(tgrls_pkg::WIN_MIN_RST), 32'(tgrls_pkg::WIN_MAX_RST), 100);
    drain();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("thrust_gain_rls_estimator_top_tb: PASS");
    end else begin
      $display("thrust_gain_rls_estimator_top_tb: FAIL");
    end
    $finish;
  end
endmodule
